// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the routing matrix modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

// ===== rtl/core/modrm_pkg.sv =====
// Package of types and constants for the modulation routing matrix
package modrm_pkg;
   localparam int MaxRoutes  = 32;
   localparam int NumTargets = 32;
   localparam int IdxW = 5;
   localparam int CntW = 6;

   localparam logic [3:0] FN_ADD = 4'd0, FN_REMOVE = 4'd1, FN_SET_AMT = 4'd2,
      FN_SET_BIP = 4'd3, FN_SET_ACT = 4'd4, FN_CLEAR = 4'd5, FN_BEGIN = 4'd6,
      FN_SAMPLE = 4'd7, FN_RD_TGT = 4'd8, FN_RD_RT = 4'd9;

   localparam logic [1:0] ST_DONE = 2'd0, ST_FULL = 2'd1, ST_BADIDX = 2'd2;

   localparam logic signed [16:0] DepthThresh = 17'sd32;
   localparam logic signed [21:0] SumMax = 22'sd2097151;
   localparam logic signed [21:0] SumMin = 22'sh200000;

   typedef struct packed {
      logic [3:0]        func;
      logic [4:0]        route_index;
      logic [3:0]        source_id;
      logic [4:0]        target_id;
      logic signed [15:0] amount;
      logic              flag;
      logic signed [15:0] sample;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [4:0]         slot;
      logic signed [21:0] target_value;
      logic [3:0]         out_source;
      logic [4:0]         out_target;
      logic signed [15:0] out_amount;
      logic               out_bipolar;
      logic               out_active;
   } rsp_type;

   // datapath commands
   typedef struct packed {
      logic load;      // capture request
      logic scan_rd;   // read slot scan_ff from the table
      logic scan_chk;  // examine registered slot read
      logic wr_new;    // append a routing
      logic wr_set;    // field edit at route_index, or matched-slot update on add
      logic shift_wr;  // copy registered slot down by one
      logic dec_cnt;
      logic clr_cnt;
      logic clr_sum;   // start sum clearing sweep
      logic rd_tgt;
      logic rd_rt;
      logic finish;    // build response
   } cmd_type;

   typedef struct packed {
      logic       valid_idx;
      logic       full;
      logic       match;     // registered slot matches source/target
      logic       scan_last; // scan_ff past the last used slot
      logic       sum_busy;
   } sts_type;
endpackage

// ===== rtl/core/modrm_datapath.sv =====
// Datapath of the routing matrix: routing table, target sums and multiply-add
module modrm_datapath
   import modrm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  req_type req,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp
);
`include "assert_macros.svh"
   typedef struct packed {
      logic [3:0]         src;
      logic [4:0]         dst;
      logic signed [15:0] depth;
      logic               bip;
      logic               on;
   } route_type;

   route_type          table_mem [MaxRoutes];
   logic signed [21:0] sum_mem [NumTargets];

   req_type            req_ff;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic [CntW-1:0]    scan_ff, scan_in;
   route_type          rd_ff;
   logic [IdxW-1:0]    rd_idx_ff;
   logic               hit_ff, hit_in;
   logic [IdxW-1:0]    hit_slot_ff, hit_slot_in;
   logic               idx_ok_ff;
   logic               app_ff;
   logic signed [33:0] prod_ff;
   logic               prod_vld_ff;
   logic [IdxW-1:0]    prod_dst_ff;
   logic               clr_busy_ff;
   logic [IdxW-1:0]    clr_idx_ff;
   rsp_type            rsp_ff, rsp_in;
   logic signed [21:0] sum_rd_ff;

   logic signed [17:0] v_c;
   logic signed [16:0] dabs_c;
   logic               use_c;
   logic signed [22:0] add_c;
   logic signed [17:0] round_c;
   logic signed [21:0] sum_new_c;

   assign cnt_in = cmd.clr_cnt ? '0 : cmd.dec_cnt ? cnt_ff - 1'b1 :
                   cmd.wr_new ? cnt_ff + 1'b1 : cnt_ff;
   // a remove walks the slots above the removed one
   assign scan_in = cmd.load ? ((req.func == FN_REMOVE) ? CntW'(req.route_index) + 1'b1 : '0) :
                    cmd.scan_rd ? scan_ff + 1'b1 : scan_ff;

   assign sts.valid_idx = idx_ok_ff;
   assign sts.full      = cnt_ff >= CntW'(MaxRoutes);
   assign sts.match     = rd_ff.src == req_ff.source_id && rd_ff.dst == req_ff.target_id;
   assign sts.scan_last = scan_ff >= cnt_ff;
   assign sts.sum_busy  = clr_busy_ff;

   assign hit_in = cmd.load ? 1'b0 : (cmd.scan_chk && sts.match && !hit_ff) ? 1'b1 : hit_ff;
   assign hit_slot_in = (cmd.scan_chk && sts.match && !hit_ff) ? rd_idx_ff : hit_slot_ff;

   // sample contribution of the registered slot
   assign v_c    = rd_ff.bip ? 18'(req_ff.sample) :
                   (18'(req_ff.sample) <<< 1) - 18'sd32768;
   assign dabs_c = rd_ff.depth < 0 ? -17'(rd_ff.depth) : 17'(rd_ff.depth);
   assign use_c  = cmd.scan_chk && req_ff.func == FN_SAMPLE &&
                   rd_ff.src == req_ff.source_id && rd_ff.on && dabs_c > DepthThresh;
   assign round_c = 18'((prod_ff + 34'sd16384) >>> 15);
   assign add_c   = 23'(sum_rd_ff) + 23'(round_c);
   assign sum_new_c = add_c > 23'(SumMax) ? SumMax : add_c < 23'(SumMin) ? SumMin : add_c[21:0];

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.finish) begin
         rsp_in = '0;
         if (req_ff.func == FN_ADD) begin
            if (hit_ff) rsp_in.slot = hit_slot_ff;
            else if (app_ff) rsp_in.slot = cnt_ff[IdxW-1:0] - 1'b1;
            else rsp_in.status = ST_FULL;
         end else if (req_ff.func == FN_REMOVE || req_ff.func == FN_SET_AMT ||
                      req_ff.func == FN_SET_BIP || req_ff.func == FN_SET_ACT ||
                      req_ff.func == FN_RD_RT) begin
            if (!sts.valid_idx) begin
               rsp_in.status = ST_BADIDX;
            end else if (req_ff.func == FN_RD_RT) begin
               rsp_in.out_source  = rd_ff.src;
               rsp_in.out_target  = rd_ff.dst;
               rsp_in.out_amount  = rd_ff.depth;
               rsp_in.out_bipolar = rd_ff.bip;
               rsp_in.out_active  = rd_ff.on;
            end
         end else if (req_ff.func == FN_RD_TGT) begin
            rsp_in.target_value = sum_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
         prod_vld_ff <= 1'b0;
         hit_ff      <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         hit_ff      <= hit_in;
         prod_vld_ff <= use_c;
         if (cmd.clr_sum) begin
            clr_busy_ff <= 1'b1;
            clr_idx_ff  <= '0;
         end else if (clr_busy_ff) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
            if (clr_idx_ff == IdxW'(NumTargets - 1)) clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      hit_slot_ff <= hit_slot_in;
      rsp_ff      <= rsp_in;
      if (cmd.load) begin
         req_ff    <= req;
         idx_ok_ff <= {1'b0, req.route_index} < cnt_ff;
         app_ff    <= 1'b0;
      end else if (cmd.wr_new) begin
         app_ff <= 1'b1;
      end
      if (cmd.scan_rd) begin
         rd_ff     <= table_mem[scan_ff[IdxW-1:0]];
         rd_idx_ff <= scan_ff[IdxW-1:0];
      end else if (cmd.rd_rt) begin
         rd_ff <= table_mem[req_ff.route_index];
      end
      // write port: append, edit, shift or add-update
      if (cmd.wr_new) begin
         table_mem[cnt_ff[IdxW-1:0]] <= {req_ff.source_id, req_ff.target_id,
                                         req_ff.amount, req_ff.flag, 1'b1};
      end else if (cmd.shift_wr) begin
         table_mem[rd_idx_ff - 1'b1] <= rd_ff;
      end else if (cmd.wr_set) begin
         if (req_ff.func == FN_ADD)
            table_mem[rd_idx_ff] <= {rd_ff.src, rd_ff.dst, req_ff.amount, req_ff.flag, 1'b1};
         else if (req_ff.func == FN_SET_AMT)
            table_mem[req_ff.route_index] <= {rd_ff.src, rd_ff.dst, req_ff.amount, rd_ff.bip,
               (req_ff.amount < 0 ? -17'(req_ff.amount) : 17'(req_ff.amount)) > DepthThresh};
         else if (req_ff.func == FN_SET_BIP)
            table_mem[req_ff.route_index] <= {rd_ff.src, rd_ff.dst, rd_ff.depth, req_ff.flag,
                                              rd_ff.on};
         else
            table_mem[req_ff.route_index] <= {rd_ff.src, rd_ff.dst, rd_ff.depth, rd_ff.bip,
                                              req_ff.flag};
      end
      // multiply stage, then read-add-write of the target sum
      if (use_c) begin
         prod_ff     <= 34'(v_c) * 34'(rd_ff.depth);
         prod_dst_ff <= rd_ff.dst;
      end
      if (cmd.rd_tgt)
         sum_rd_ff <= sum_mem[req_ff.target_id];
      else if (use_c)
         sum_rd_ff <= sum_mem[rd_ff.dst];
      if (clr_busy_ff)
         sum_mem[clr_idx_ff] <= '0;
      else if (prod_vld_ff)
         sum_mem[prod_dst_ff] <= sum_new_c;
   end

   assign rsp = rsp_ff;

   `ASSERT_NEVER(a_cnt_range, clock, reset, cnt_ff > CntW'(MaxRoutes), "route count overflow")
   `ASSERT_NEVER(a_no_wr_clear, clock, reset, clr_busy_ff && prod_vld_ff, "sum update in clear")
   `ASSERT_CLK(a_dec_valid, clock, reset, cmd.dec_cnt |-> cnt_ff != '0, "remove on empty table")
endmodule

// ===== rtl/core/modrm_ctrl.sv =====
// Controller state machine of the routing matrix
module modrm_ctrl
   import modrm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  req_type req,
   input  sts_type sts,
   output cmd_type cmd
);
`include "assert_macros.svh"
   localparam logic [3:0] S_IDLE = 4'd0, S_DISPATCH = 4'd1, S_SCAN = 4'd2, S_CHK = 4'd3,
      S_EDIT_RD = 4'd4, S_EDIT_WR = 4'd5, S_SHIFT = 4'd6, S_SHIFT_WR = 4'd7,
      S_RD = 4'd8, S_RD2 = 4'd9, S_FIN = 4'd10, S_DRAIN = 4'd11, S_OUT = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [3:0] func_ff, func_in;
   logic [1:0] drain_ff, drain_in;

   assign req_tready = state_ff == S_IDLE && !sts.sum_busy;
   assign rsp_tvalid = state_ff == S_OUT;
   assign func_in = (req_tvalid && req_tready) ? req.func : func_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      drain_in = drain_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && !sts.sum_busy) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (func_ff)
               FN_ADD, FN_SAMPLE: state_in = S_SCAN;
               FN_REMOVE: state_in = sts.valid_idx ? S_SHIFT : S_FIN;
               FN_SET_AMT, FN_SET_BIP, FN_SET_ACT:
                  state_in = sts.valid_idx ? S_EDIT_RD : S_FIN;
               FN_CLEAR: begin
                  cmd.clr_cnt = 1'b1;
                  cmd.clr_sum = 1'b1;
                  state_in = S_FIN;
               end
               FN_BEGIN: begin
                  cmd.clr_sum = 1'b1;
                  state_in = S_FIN;
               end
               FN_RD_TGT: begin
                  cmd.rd_tgt = 1'b1;
                  state_in = S_RD2;
               end
               FN_RD_RT: begin
                  cmd.rd_rt = sts.valid_idx;
                  state_in = S_RD2;
               end
               default: state_in = S_FIN;
            endcase
         end
         // each slot is read in S_SCAN, then examined in S_CHK before the next read
         S_SCAN: begin
            if (sts.scan_last) begin
               drain_in = 2'd3;
               state_in = S_DRAIN;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            cmd.scan_chk = 1'b1;
            if (func_ff == FN_ADD && sts.match) begin
               cmd.wr_set = 1'b1;
               state_in = S_FIN;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_DRAIN: begin
            // let the last multiply-add settle; append on a missed add
            if (drain_ff == 2'd3 && func_ff == FN_ADD && !sts.full) cmd.wr_new = 1'b1;
            drain_in = drain_ff - 1'b1;
            if (drain_ff == 2'd0) state_in = S_FIN;
         end
         S_EDIT_RD: begin
            cmd.rd_rt = 1'b1;
            state_in = S_EDIT_WR;
         end
         S_EDIT_WR: begin
            cmd.wr_set = 1'b1;
            state_in = S_FIN;
         end
         // read the slot above, then copy it down
         S_SHIFT: begin
            if (sts.scan_last) begin
               cmd.dec_cnt = 1'b1;
               state_in = S_FIN;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in = S_SHIFT;
         end
         S_RD2: state_in = S_RD;
         S_RD:  state_in = S_FIN;
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         func_ff  <= '0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         func_ff  <= func_in;
         drain_ff <= drain_in;
      end
   end

   `ASSERT_CLK(a_one_cmd, clock, reset, $onehot0({cmd.wr_new, cmd.shift_wr, cmd.wr_set}), "clash")
   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> rsp_tvalid, "response dropped")
   `ASSERT_NEVER(a_busy_accept, clock, reset, req_tready && state_ff != S_IDLE, "accept while busy")
endmodule

// ===== rtl/core/modulation_routing_matrix_top.sv =====
// Modulation routing matrix: compacted table of up to 32 routings with target sums.
// Each item yields one response item. Add and sample walk the used slots through the
// table read port, reading each slot and then examining it; remove copies the slots
// above the removed one down. After reset, and after a clear or begin-frame item,
// the 32 target sums are zeroed one per cycle and no item is taken during that pass.
module modulation_routing_matrix_top
   import modrm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // func, route_index, source_id, target_id, amount, flag, sample (lowest first)
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status, slot, target_value, out_source, out_target, out_amount,
   // out_bipolar, out_active (lowest first)
   output logic [55:0] rsp_tdata
);
   req_type req;
   rsp_type rsp;
   cmd_type cmd;
   sts_type sts;

   assign req.func        = req_tdata[3:0];
   assign req.route_index = req_tdata[8:4];
   assign req.source_id   = req_tdata[12:9];
   assign req.target_id   = req_tdata[17:13];
   assign req.amount      = req_tdata[33:18];
   assign req.flag        = req_tdata[34];
   assign req.sample      = req_tdata[50:35];

   function automatic logic [55:0] curly_pad(input rsp_type r);
      curly_pad = {r.out_active, r.out_bipolar, r.out_amount, r.out_target,
                   r.out_source, r.target_value, r.slot, r.status};
   endfunction

   assign rsp_tdata = curly_pad(rsp);

   modrm_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .req, .sts, .cmd
   );

   modrm_datapath u_dp (
      .clock, .reset, .req, .cmd, .sts, .rsp
   );
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the modulation routing matrix
`timescale 1ns / 100ps

module testbench;
   import modrm_pkg::*;

   localparam int ClockPeriod = 8;
   localparam int CycleLimit  = 400000;

   typedef struct {
      logic [1:0]         status;
      logic [4:0]         slot;
      logic signed [21:0] target_value;
      logic [3:0]         out_source;
      logic [4:0]         out_target;
      logic signed [15:0] out_amount;
      logic               out_bipolar;
      logic               out_active;
   } answer_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;

   // shadow of the routing table and the target sums
   logic [3:0]         tbl_src [MaxRoutes];
   logic [4:0]         tbl_dst [MaxRoutes];
   logic signed [15:0] tbl_depth [MaxRoutes];
   logic               tbl_bip [MaxRoutes];
   logic               tbl_on [MaxRoutes];
   int                 tbl_count;
   logic signed [21:0] sums [NumTargets];

   answer_type answers_due[$];
   int         error_count;
   int         cycle_count;
   int         burst_left;

   modulation_routing_matrix_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   function automatic int mag(input logic signed [15:0] a);
      return (a < 0) ? -int'(a) : int'(a);
   endfunction

   // advance the shadow table by one item and return the answer it gives
   function automatic answer_type route_answer(input req_type r);
      answer_type a;
      longint v, p, s;
      int i;
      a = '{default: '0};
      case (r.func)
         FN_ADD: begin
            for (i = 0; i < tbl_count; i++) begin
               if (tbl_src[i] == r.source_id && tbl_dst[i] == r.target_id) begin
                  tbl_depth[i] = r.amount;
                  tbl_bip[i] = r.flag;
                  tbl_on[i] = 1'b1;
                  a.slot = 5'(i);
                  return a;
               end
            end
            if (tbl_count >= MaxRoutes) begin
               a.status = ST_FULL;
               return a;
            end
            i = tbl_count++;
            tbl_src[i] = r.source_id;
            tbl_dst[i] = r.target_id;
            tbl_depth[i] = r.amount;
            tbl_bip[i] = r.flag;
            tbl_on[i] = 1'b1;
            a.slot = 5'(i);
         end
         FN_REMOVE, FN_SET_AMT, FN_SET_BIP, FN_SET_ACT, FN_RD_RT: begin
            if (int'(r.route_index) >= tbl_count) begin
               a.status = ST_BADIDX;
               return a;
            end
            i = int'(r.route_index);
            case (r.func)
               FN_REMOVE: begin
                  for (; i + 1 < tbl_count; i++) begin
                     tbl_src[i] = tbl_src[i + 1];
                     tbl_dst[i] = tbl_dst[i + 1];
                     tbl_depth[i] = tbl_depth[i + 1];
                     tbl_bip[i] = tbl_bip[i + 1];
                     tbl_on[i] = tbl_on[i + 1];
                  end
                  tbl_count--;
               end
               FN_SET_AMT: begin
                  tbl_depth[i] = r.amount;
                  tbl_on[i] = mag(r.amount) > DepthThresh;
               end
               FN_SET_BIP: tbl_bip[i] = r.flag;
               FN_SET_ACT: tbl_on[i] = r.flag;
               default: begin
                  a.out_source = tbl_src[i];
                  a.out_target = tbl_dst[i];
                  a.out_amount = tbl_depth[i];
                  a.out_bipolar = tbl_bip[i];
                  a.out_active = tbl_on[i];
               end
            endcase
         end
         FN_CLEAR: begin
            tbl_count = 0;
            foreach (sums[k]) sums[k] = '0;
         end
         FN_BEGIN: foreach (sums[k]) sums[k] = '0;
         FN_SAMPLE: begin
            for (i = 0; i < tbl_count; i++) begin
               if (tbl_src[i] != r.source_id || !tbl_on[i]) continue;
               if (mag(tbl_depth[i]) <= DepthThresh) continue;
               v = tbl_bip[i] ? longint'(r.sample) : 2 * longint'(r.sample) - 32768;
               p = v * longint'(tbl_depth[i]) + 16384;
               s = longint'(sums[tbl_dst[i]]) + (p >>> 15);
               if (s > SumMax) s = SumMax;
               if (s < SumMin) s = SumMin;
               sums[tbl_dst[i]] = s[21:0];
            end
         end
         FN_RD_TGT: a.target_value = sums[r.target_id];
         default: ;
      endcase
      return a;
   endfunction

   // hand one item over, honouring the burst and gap pattern
   task automatic send_item(input req_type r);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= 56'({r.sample, r.flag, r.amount, r.target_id, r.source_id,
                        r.route_index, r.func});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      answers_due = {answers_due, route_answer(r)};
   endtask

   task automatic send_cmd(input logic [3:0] fn, input int idx, input int src,
                           input int dst, input int amt, input int flg, input int smp);
      req_type r;
      r.func = fn;
      r.route_index = 5'(idx);
      r.source_id = 4'(src);
      r.target_id = 5'(dst);
      r.amount = 16'(amt);
      r.flag = 1'(flg);
      r.sample = 16'(smp);
      send_item(r);
   endtask

   task automatic drain_answers();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (answers_due.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_cmd(FN_RD_RT, 0, 0, 0, 0, 0, 0);
      send_cmd(FN_REMOVE, 31, 0, 0, 0, 0, 0);
      send_cmd(FN_ADD, 0, 15, 31, 32767, 1, 0);
      send_cmd(FN_ADD, 0, 0, 0, -32768, 0, 0);
      send_cmd(FN_ADD, 0, 15, 31, -32768, 1, 0);
      send_cmd(FN_ADD, 0, 3, 5, 33, 0, 0);
      send_cmd(FN_SET_AMT, 2, 0, 0, 32, 0, 0);
      send_cmd(FN_SET_AMT, 2, 0, 0, -33, 0, 0);
      send_cmd(FN_SET_BIP, 1, 0, 0, 0, 1, 0);
      send_cmd(FN_SET_ACT, 0, 0, 0, 0, 0, 0);
      send_cmd(FN_RD_RT, 1, 0, 0, 0, 0, 0);
      send_cmd(FN_BEGIN, 0, 0, 0, 0, 0, 0);
      send_cmd(FN_SAMPLE, 0, 0, 0, 0, 0, 32767);
      send_cmd(FN_SAMPLE, 0, 0, 0, 0, 0, -32768);
      send_cmd(FN_SAMPLE, 0, 3, 0, 0, 0, 0);
      send_cmd(FN_RD_TGT, 0, 0, 0, 0, 0, 0);
      send_cmd(FN_RD_TGT, 0, 0, 5, 0, 0, 0);
      send_cmd(FN_RD_TGT, 0, 0, 31, 0, 0, 0);
      send_cmd(FN_REMOVE, 0, 0, 0, 0, 0, 0);
      send_cmd(FN_RD_RT, 0, 0, 0, 0, 0, 0);
      send_cmd(4'd10, 31, 15, 31, -1, 1, -1);
      send_cmd(4'd15, 0, 0, 0, 0, 0, 0);
      send_cmd(FN_CLEAR, 0, 0, 0, 0, 0, 0);
      send_cmd(FN_RD_RT, 0, 0, 0, 0, 0, 0);
   endtask

   // fill the table to overflow, then saturate some sums upwards and others downwards
   task automatic test_full_and_saturation();
      for (int i = 0; i < MaxRoutes + 2; i++)
         send_cmd(FN_ADD, 0, i % 2, i, (i % 2) ? -32768 : 32767, 1, 0);
      drain_answers();
      send_cmd(FN_BEGIN, 0, 0, 0, 0, 0, 0);
      repeat (80) send_cmd(FN_SAMPLE, 0, 0, 0, 0, 0, 32767);
      repeat (160) send_cmd(FN_SAMPLE, 0, 1, 0, 0, 0, 32767);
      for (int t = 0; t < 4; t++) send_cmd(FN_RD_TGT, 0, 0, t, 0, 0, 0);
      send_cmd(FN_ADD, 0, 9, 9, 100, 0, 0);
      send_cmd(FN_CLEAR, 0, 0, 0, 0, 0, 0);
   endtask

   // frames of adds, removes, edits, clears, samples and reads with random content, plus noise
   task automatic test_random_frames(input int items);
      int sent;
      int fn;
      sent = 0;
      while (sent < items) begin
         fn = $urandom_range(0, 99);
         if (fn < 14)
            send_cmd(FN_ADD, 0, $urandom_range(0, 3), $urandom_range(0, 31),
                     $urandom, $urandom, 0);
         else if (fn < 20)
            send_cmd(FN_REMOVE, $urandom_range(0, 31), 0, 0, 0, 0, 0);
         else if (fn < 26)
            send_cmd(FN_SET_AMT, $urandom_range(0, 31), 0, 0,
                     ($urandom_range(0, 1)) ? $urandom_range(0, 80) - 40 : $urandom,
                     0, 0);
         else if (fn < 30)
            send_cmd(FN_SET_BIP, $urandom_range(0, 31), 0, 0, 0, $urandom, 0);
         else if (fn < 34)
            send_cmd(FN_SET_ACT, $urandom_range(0, 31), 0, 0, 0, $urandom, 0);
         else if (fn < 36)
            send_cmd(FN_BEGIN, 0, 0, 0, 0, 0, 0);
         else if (fn < 37)
            send_cmd(FN_CLEAR, 0, 0, 0, 0, 0, 0);
         else if (fn < 62)
            send_cmd(FN_SAMPLE, 0, $urandom_range(0, 15), 0, 0, 0, $urandom);
         else if (fn < 78)
            send_cmd(FN_RD_TGT, 0, 0, $urandom_range(0, 31), 0, 0, 0);
         else if (fn < 94)
            send_cmd(FN_RD_RT, $urandom_range(0, 31), 0, 0, 0, 0, 0);
         else
            send_cmd(4'($urandom_range(10, 15)), $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom);
         sent++;
      end
   endtask

   // response side: stall on its own pattern and compare each item
   always @(posedge clock) begin
      answer_type want;
      rsp_type got;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ((cycle_count % 97) < 60) ? 1'b1 : ($urandom_range(0, 3) != 0);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'({rsp_tdata[1:0], rsp_tdata[6:2], rsp_tdata[28:7],
                             rsp_tdata[32:29], rsp_tdata[37:33], rsp_tdata[53:38],
                             rsp_tdata[54], rsp_tdata[55]});
            if (answers_due.size() == 0) begin
               $display("%0t: unexpected item %h", $time, rsp_tdata);
               error_count++;
            end else begin
               want = answers_due.pop_front();
               if (got.status !== want.status || got.slot !== want.slot ||
                   got.target_value !== want.target_value ||
                   got.out_source !== want.out_source ||
                   got.out_target !== want.out_target ||
                   got.out_amount !== want.out_amount ||
                   got.out_bipolar !== want.out_bipolar ||
                   got.out_active !== want.out_active) begin
                  $display("%0t: expected st=%0d slot=%0d sum=%0d rt=%0d/%0d/%0d/%0d/%0d",
                           $time, want.status, want.slot, want.target_value,
                           want.out_source, want.out_target, want.out_amount,
                           want.out_bipolar, want.out_active);
                  $display("%0t: actual   st=%0d slot=%0d sum=%0d rt=%0d/%0d/%0d/%0d/%0d",
                           $time, got.status, got.slot, got.target_value,
                           got.out_source, got.out_target, got.out_amount,
                           got.out_bipolar, got.out_active);
                  error_count++;
               end
            end
         end
      end
      if (cycle_count >= CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      error_count = 0;
      cycle_count = 0;
      burst_left = 0;
      tbl_count = 0;
      foreach (sums[k]) sums[k] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      drain_answers();
      test_full_and_saturation();
      test_random_frames(450);
      drain_answers();
      repeat (40) @(posedge clock);
      test_random_frames(200);
      drain_answers();
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/modrm_pkg.sv
rtl/core/modrm_datapath.sv
rtl/core/modrm_ctrl.sv
rtl/core/modulation_routing_matrix_top.sv
tb/testbench.sv
